### sv/ghash_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ghash_pkg
// Shared widths, register indexes and types for the GHASH authenticator.
// -----------------------------------------------------------------------------
package ghash_pkg;

    // Field and datapath widths
    localparam int HALF_W  = 64;
    localparam int BLK_W   = 2 * HALF_W;
    localparam int CNT_W   = 5;
    localparam int BYTES_W = 61;
    localparam int LEN_W   = 3;                // bytes to bits shift
    localparam int CFG_IDX_W = 2;

    // Multiplier digit size: operand bits consumed per cycle
    localparam int DIGIT_W = 8;
    localparam int STEPS   = BLK_W / DIGIT_W;
    localparam int STEP_W  = $clog2(STEPS);

    // Bytes in one block
    localparam int BLK_BYTES = BLK_W / 8;

    // Reflected reduction constant for GF(2^128)
    localparam logic [BLK_W-1:0] GH_REDUCE = {8'hE1, {(BLK_W - 8){1'b0}}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_KEY_HI = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_KEY_LO = CFG_IDX_W'(1);

    // Multiplier status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage
`default_nettype wire

### sv/ghash_ifs.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ghash interfaces
// Valid/ready channels for data items, configuration writes and tags.
// -----------------------------------------------------------------------------

// Data block item
interface ghash_in_if;
    logic                         valid;
    logic                         ready;
    logic [ghash_pkg::HALF_W-1:0] block_hi;
    logic [ghash_pkg::HALF_W-1:0] block_lo;
    logic [ghash_pkg::CNT_W-1:0]  byte_count;
    logic                         last;

    modport source (output valid, block_hi, block_lo, byte_count, last, input ready);
    modport sink   (input valid, block_hi, block_lo, byte_count, last, output ready);
endinterface

// Tag item
interface ghash_out_if;
    logic                         valid;
    logic                         ready;
    logic [ghash_pkg::HALF_W-1:0] tag_hi;
    logic [ghash_pkg::HALF_W-1:0] tag_lo;

    modport source (output valid, tag_hi, tag_lo, input ready);
    modport sink   (input valid, tag_hi, tag_lo, output ready);
endinterface

// Register write
interface ghash_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ghash_pkg::CFG_IDX_W-1:0] index;
    logic [ghash_pkg::HALF_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/ghash_gf128_authenticator.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ghash_gf128_authenticator
// GCM GHASH over message blocks with key H in two registers; emits the tag.
// -----------------------------------------------------------------------------
//  Channel  Dir  Payload                               Handshake
//  i_in     in   block_hi, block_lo, byte_count, last  valid/ready
//  i_cfg    in   index, data (hash key halves)         valid/ready, always ready
//  o_tag    out  tag_hi, tag_lo                        valid/ready
//
//  A block with nonzero count passes through the multiplier once, then the
//  sequencer returns to idle; a last item adds a multiply of the length block
//  and a load of the tag register. The 8-bit-per-cycle GF multiplier sets the
//  pace.
//  Reset clears the key, accumulator and byte total. A waiting tag stalls the
//  next tag only; a full tag register holds the sequencer before loading.
// -----------------------------------------------------------------------------
module ghash_gf128_authenticator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ghash_in_if.sink   i_in,
    ghash_cfg_if.sink  i_cfg,
    ghash_out_if.source o_tag
);
    import ghash_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DATA  = 4'b0010,
        S_LEN   = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [BLK_W-1:0]   r_acc, n_acc;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic               r_last, n_last;
    logic [BLK_W-1:0]   r_tag, n_tag;
    logic               r_tag_vld, n_tag_vld;
    logic [HALF_W-1:0]  r_key_hi;
    logic [HALF_W-1:0]  r_key_lo;

    logic               in_acc;
    logic               tag_free;
    logic [CNT_W-1:0]   cnt_sat;
    logic [BLK_W-1:0]   pad_mask;
    logic [BLK_W-1:0]   len_blk;
    logic               mul_start;
    logic [BLK_W-1:0]   mul_x;
    logic [BLK_W-1:0]   mul_prod;
    t_mul_stat          mul_stat;

    // Shared multiplier
    ghash_gfmul u_gfmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_key   ({r_key_hi, r_key_lo}),
        .o_prod  (mul_prod),
        .o_stat  (mul_stat)
    );

    // Key registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_HASH_KEY_HI: r_key_hi <= i_cfg.data;
                CFG_HASH_KEY_LO: r_key_lo <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Saturate count and build the leading-byte mask
    always_comb begin
        cnt_sat = (i_in.byte_count > CNT_W'(BLK_BYTES)) ? CNT_W'(BLK_BYTES)
                                                        : i_in.byte_count;
        for (int i = 0; i < BLK_BYTES; i++) begin
            pad_mask[BLK_W-1-8*i -: 8] = (CNT_W'(i) < cnt_sat) ? 8'hFF : 8'h00;
        end
    end

    assign len_blk  = {{HALF_W{1'b0}}, r_bytes, {LEN_W{1'b0}}};
    assign in_acc   = i_in.valid && i_in.ready;
    assign tag_free = !r_tag_vld || o_tag.ready;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_bytes   = r_bytes;
        n_last    = r_last;
        n_tag     = r_tag;
        n_tag_vld = r_tag_vld && !o_tag.ready;
        mul_start = 1'b0;
        mul_x     = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (cnt_sat != '0) begin
                        mul_start = 1'b1;
                        mul_x     = r_acc ^ ({i_in.block_hi, i_in.block_lo} & pad_mask);
                        n_bytes   = r_bytes + BYTES_W'(cnt_sat);
                        n_last    = i_in.last;
                        n_state   = S_DATA;
                    end else if (i_in.last) begin
                        mul_start = 1'b1;
                        mul_x     = r_acc ^ len_blk;
                        n_state   = S_LEN;
                    end
                end
            end
            S_DATA: begin
                if (mul_stat.done) begin
                    n_acc = mul_prod;
                    if (r_last) begin
                        mul_start = 1'b1;
                        mul_x     = mul_prod ^ len_blk;
                        n_state   = S_LEN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LEN: begin
                if (mul_stat.done) begin
                    n_acc   = mul_prod;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (tag_free) begin
                    n_tag     = r_acc;
                    n_tag_vld = 1'b1;
                    n_acc     = '0;
                    n_bytes   = '0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= '0;
            r_bytes   <= '0;
            r_last    <= 1'b0;
            r_tag_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_bytes   <= n_bytes;
            r_last    <= n_last;
            r_tag_vld <= n_tag_vld;
        end
    end

    // Tag payload
    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_tag.valid  = r_tag_vld;
    assign o_tag.tag_hi = r_tag[BLK_W-1:HALF_W];
    assign o_tag.tag_lo = r_tag[HALF_W-1:0];

    // Checks
    a_idle_mul_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !mul_stat.busy)
        else $error("input ready while multiplier busy");

    a_done_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> (r_state == S_DATA || r_state == S_LEN))
        else $error("multiplier done outside a work state");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && tag_free) |=> (r_acc == '0 && r_bytes == '0 && r_tag_vld))
        else $error("tag load did not clear message state");

endmodule
`default_nettype wire

### sv/ghash_gfmul.sv
`default_nettype none
// -----------------------------------------------------------------------------
// ghash_gfmul
// Digit-serial GF(2^128) multiplier, GCM bit order, eight bits per cycle.
// -----------------------------------------------------------------------------
module ghash_gfmul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ghash_pkg::BLK_W-1:0]   i_x,
    input  wire logic [ghash_pkg::BLK_W-1:0]   i_key,
    output logic      [ghash_pkg::BLK_W-1:0]   o_prod,
    output ghash_pkg::t_mul_stat               o_stat
);
    import ghash_pkg::*;

    logic [BLK_W-1:0]  r_x;
    logic [BLK_W-1:0]  r_z;
    logic [BLK_W-1:0]  r_v;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [BLK_W-1:0]  n_z;
    logic [BLK_W-1:0]  n_v;

    // One digit: accumulate shifted key for each set bit, MSB first
    always_comb begin
        logic carry;
        n_z = r_z;
        n_v = r_v;
        for (int j = 0; j < DIGIT_W; j++) begin
            if (r_x[BLK_W-1-j]) begin
                n_z = n_z ^ n_v;
            end
            carry = n_v[0];
            n_v   = (n_v >> 1) ^ (carry ? GH_REDUCE : '0);
        end
    end

    // Start on request, then advance one digit a cycle while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and product registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_v <= i_key;
            r_z <= '0;
        end else if (r_busy) begin
            r_x <= r_x << DIGIT_W;
            r_v <= n_v;
            r_z <= n_z;
        end
    end

    assign o_prod      = r_z;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
`default_nettype wire
